// ===== sv/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dcr_pkg
// shared types, constants and the gain scale table of the adc frame dc
// removal block
// ----------------------------------------------------------------------------
package dcr_pkg;

	// default frame geometry
	localparam int DEVICES_DEF             = 4;
	localparam int FRAME_BYTES_DEF         = 30;
	localparam int CHANNELS_PER_DEVICE_DEF = 6;
	localparam int USED_CHANNELS_DEF       = 24;

	// fixed frame layout
	localparam int STATUS_BYTES = 3;
	localparam int WORD_BYTES   = 3;

	// field widths
	localparam int BYTE_W      = 8;
	localparam int SAMPLE_W    = 24;
	localparam int CH_IDX_W    = 6;
	localparam int CHANNEL_W   = 5;
	localparam int RESULT_W    = 32;
	localparam int COUNT_W     = 32;
	localparam int GAIN_DB_W   = 7;
	localparam int SCALE_W     = 40;
	localparam int SCALE_HALF  = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DB = 2'd1;

	// byte position inside a 24-bit word
	localparam logic [1:0] WB_HI  = 2'd0;
	localparam logic [1:0] WB_MID = 2'd1;
	localparam logic [1:0] WB_LO  = 2'd2;

	// assembled word handed from the parser to the datapath
	typedef struct packed {
		logic [CH_IDX_W-1:0]        ch;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} word_item_t;

	// 10^(r/20) in q16, rounded
	typedef logic [SCALE_HALF-1:0] gain_base_t [20];
	localparam gain_base_t GAIN_BASE_Q16 = '{
		20'd65536,  20'd73533,  20'd82505,  20'd92572,  20'd103868,
		20'd116541, 20'd130762, 20'd146717, 20'd164619, 20'd184706,
		20'd207243, 20'd232531, 20'd260904, 20'd292739, 20'd328458,
		20'd368536, 20'd413504, 20'd463959, 20'd520571, 20'd584090
	};

	typedef logic [SCALE_W-1:0] gain_tbl_t [2**GAIN_DB_W];

	// scale for every gain step: base of the step within its decade times 10^decade
	function automatic gain_tbl_t build_gain_table();
		gain_tbl_t          tbl;
		logic [SCALE_W-1:0] decade;
		int                 idx;
		decade = SCALE_W'(1);
		for (int i = 0; i < 2**GAIN_DB_W; i++) begin
			tbl[i] = '0;
		end
		for (int k = 0; k < 7; k++) begin
			for (int r = 0; r < 20; r++) begin
				idx = k * 20 + r;
				if (idx < 2**GAIN_DB_W) begin
					tbl[idx] = SCALE_W'(decade * SCALE_W'(GAIN_BASE_Q16[r]));
				end
			end
			decade = SCALE_W'(decade * SCALE_W'(10));
		end
		return tbl;
	endfunction

	localparam gain_tbl_t GAIN_SCALE_TABLE = build_gain_table();

endpackage

// ===== sv/dcr_if.sv =====
// ----------------------------------------------------------------------------
// dcr_if
// channel interfaces: raw byte stream, result stream and register writes
// ----------------------------------------------------------------------------
interface dcr_byte_if import dcr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] raw_byte;
	logic              frame_start;

	modport source (output valid, output raw_byte, output frame_start, input ready);
	modport sink (input valid, input raw_byte, input frame_start, output ready);
endinterface

interface dcr_result_if import dcr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CHANNEL_W-1:0]       channel;
	logic signed [RESULT_W-1:0] sample_value;
	logic                       last_of_frame;
	logic [COUNT_W-1:0]         frame_count;

	modport source (output valid, output channel, output sample_value,
		output last_of_frame, output frame_count, input ready);
	modport sink (input valid, input channel, input sample_value,
		input last_of_frame, input frame_count, output ready);
endinterface

interface dcr_cfg_if import dcr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/adc_frame_dc_removal.sv =====
// ----------------------------------------------------------------------------
// adc_frame_dc_removal
// per-channel dc offset removal and digital gain for a daisy-chained 24-bit
// adc frame received one byte at a time
//
//   channel    dir   transaction
//   adc_bytes  in    one frame byte, frame_start on the first byte of a frame
//   results    out   one corrected, scaled sample per used channel
//   cfg        in    register write: 0 enable, 1 gain_db (always ready)
//
// one byte per cycle is accepted while the word queue has room; a word result
// passes from the word queue through the dc tracker and the multiply stage,
// then saturates into the output register
// the parser only waits when the four-entry word queue is full; the datapath
// advances whenever the output register is empty or taken
// reset clears position, dc offsets, frame counter and configuration registers at once
// ----------------------------------------------------------------------------
module adc_frame_dc_removal import dcr_pkg::*; #(
	parameter int DEVICES             = DEVICES_DEF,
	parameter int FRAME_BYTES         = FRAME_BYTES_DEF,
	parameter int CHANNELS_PER_DEVICE = CHANNELS_PER_DEVICE_DEF,
	parameter int USED_CHANNELS       = USED_CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dcr_byte_if.sink     adc_bytes,
	dcr_result_if.source results,
	dcr_cfg_if.sink      cfg
);

	logic                 enable_q;
	logic [GAIN_DB_W-1:0] gain_db_q;
	logic                 push, queue_full, pop_valid, pop_ready;
	word_item_t           push_item, pop_item;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			gain_db_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE:  enable_q  <= cfg.data[0];
				REG_GAIN_DB: gain_db_q <= cfg.data[GAIN_DB_W-1:0];
				default: ;
			endcase
		end
	end

	// byte parser
	dcr_front #(
		.DEVICES             (DEVICES),
		.FRAME_BYTES         (FRAME_BYTES),
		.CHANNELS_PER_DEVICE (CHANNELS_PER_DEVICE),
		.USED_CHANNELS       (USED_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (enable_q),
		.adc_bytes  (adc_bytes),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// word queue
	dcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready)
	);

	// sample datapath
	dcr_back #(
		.USED_CHANNELS (USED_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain_db    (gain_db_q),
		.item_valid (pop_valid),
		.item       (pop_item),
		.item_ready (pop_ready),
		.results    (results)
	);

endmodule

// ===== sv/dcr_front.sv =====
// ----------------------------------------------------------------------------
// dcr_front
// byte parser: tracks the position in the chained frame, skips status bytes
// and unused slots, assembles 24-bit words and queues one item per used channel
// ----------------------------------------------------------------------------
module dcr_front import dcr_pkg::*; #(
	parameter int DEVICES             = DEVICES_DEF,
	parameter int FRAME_BYTES         = FRAME_BYTES_DEF,
	parameter int CHANNELS_PER_DEVICE = CHANNELS_PER_DEVICE_DEF,
	parameter int USED_CHANNELS       = USED_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enable,
	dcr_byte_if.sink   adc_bytes,
	input  logic       queue_full,
	output logic       push,
	output word_item_t push_item
);

	localparam int FIT     = (FRAME_BYTES - STATUS_BYTES) / WORD_BYTES;
	localparam int SLOTS   = (CHANNELS_PER_DEVICE < FIT) ? CHANNELS_PER_DEVICE : FIT;
	localparam int USABLE  = DEVICES * SLOTS;
	localparam int LAST_CH = ((USED_CHANNELS < USABLE) ? USED_CHANNELS : USABLE) - 1;
	localparam int OFF_W   = $clog2(FRAME_BYTES);
	localparam int DEV_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int SLOT_W  = $clog2(FIT + 1);
	localparam int CH_W    = $clog2(DEVICES * CHANNELS_PER_DEVICE + FIT + USED_CHANNELS + 1);

	logic [OFF_W-1:0]  off_q, c_off;
	logic [DEV_W-1:0]  dev_q, c_dev;
	logic [SLOT_W-1:0] slot_q, c_slot;
	logic [1:0]        sub_q, c_sub;
	logic [CH_W-1:0]   base_q, c_base, ch_full;
	logic              done_q, c_done;
	logic [BYTE_W-1:0] hi_q, mid_q;
	logic              take, active, status, in_slot;

	assign adc_bytes.ready = !queue_full;

	// bytes taken while disabled are dropped
	assign take = adc_bytes.valid && adc_bytes.ready && enable;

	// position of this byte, restarted by a frame start
	always_comb begin
		if (adc_bytes.frame_start) begin
			c_off  = '0;
			c_dev  = '0;
			c_slot = '0;
			c_sub  = WB_HI;
			c_base = '0;
			c_done = 1'b0;
		end else begin
			c_off  = off_q;
			c_dev  = dev_q;
			c_slot = slot_q;
			c_sub  = sub_q;
			c_base = base_q;
			c_done = done_q;
		end
	end

	// classify the byte
	assign active  = take && !c_done;
	assign status  = c_off < OFF_W'(STATUS_BYTES);
	assign in_slot = !status && (c_slot < SLOT_W'(SLOTS));
	assign ch_full = c_base + CH_W'(c_slot);
	assign push    = active && in_slot && (c_sub == WB_LO) && (ch_full < CH_W'(USED_CHANNELS));

	always_comb begin
		push_item.ch     = CH_IDX_W'(ch_full);
		push_item.sample = {hi_q, mid_q, adc_bytes.raw_byte};
		push_item.last   = ch_full == CH_W'(LAST_CH);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			dev_q  <= '0;
			slot_q <= '0;
			sub_q  <= WB_HI;
			base_q <= '0;
			done_q <= 1'b0;
		end else if (active) begin
			if (c_off == OFF_W'(FRAME_BYTES - 1)) begin
				off_q  <= '0;
				slot_q <= '0;
				sub_q  <= WB_HI;
				base_q <= c_base + CH_W'(CHANNELS_PER_DEVICE);
				dev_q  <= c_dev + DEV_W'(1);
				done_q <= c_dev == DEV_W'(DEVICES - 1);
			end else begin
				off_q  <= c_off + OFF_W'(1);
				base_q <= c_base;
				dev_q  <= c_dev;
				done_q <= 1'b0;
				if (status) begin
					slot_q <= '0;
					sub_q  <= WB_HI;
				end else if (c_sub == WB_LO) begin
					slot_q <= c_slot + SLOT_W'(1);
					sub_q  <= WB_HI;
				end else begin
					slot_q <= c_slot;
					sub_q  <= c_sub + 2'd1;
				end
			end
		end
	end

	// upper bytes of the word in progress
	always_ff @(posedge clk) begin
		if (active && in_slot && c_sub == WB_HI) begin
			hi_q <= adc_bytes.raw_byte;
		end
		if (active && in_slot && c_sub == WB_MID) begin
			mid_q <= adc_bytes.raw_byte;
		end
	end

endmodule

// ===== sv/dcr_queue.sv =====
// ----------------------------------------------------------------------------
// dcr_queue
// short word queue between the byte parser and the sample datapath
// ----------------------------------------------------------------------------
module dcr_queue import dcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  word_item_t push_item,
	output logic       full,
	output logic       pop_valid,
	output word_item_t pop_item,
	input  logic       pop_ready
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	word_item_t       entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = entries_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/dcr_back.sv =====
// ----------------------------------------------------------------------------
// dcr_back
// sample datapath: per-channel dc tracker, offset subtraction, gain multiply
// split in two partial products, saturation and the frame counter
// ----------------------------------------------------------------------------
module dcr_back import dcr_pkg::*; #(
	parameter int USED_CHANNELS = USED_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [GAIN_DB_W-1:0] gain_db,
	input  logic                 item_valid,
	input  word_item_t           item,
	output logic                 item_ready,
	dcr_result_if.source         results
);

	localparam int IDX_W  = (USED_CHANNELS > 1) ? $clog2(USED_CHANNELS) : 1;
	localparam int T_W    = SAMPLE_W + 4;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PP_W   = DIFF_W + SCALE_HALF;
	localparam int PROD_W = DIFF_W + SCALE_W;
	localparam int Q_W    = PROD_W - 16;

	logic signed [SAMPLE_W-1:0] dc_offsets_q [USED_CHANNELS];
	logic [SCALE_W-1:0]         scale_q;

	logic                       adv;
	logic [IDX_W-1:0]           idx;
	logic signed [SAMPLE_W-1:0] old_offs, new_offs;
	logic signed [T_W-1:0]      t_sum, t_adj;

	logic                       v_s1, last_s1;
	logic [CH_IDX_W-1:0]        ch_s1;
	logic signed [SAMPLE_W-1:0] sample_s1, offs_s1;

	logic signed [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]          mag;
	logic                       v_s2, last_s2, neg_s2;
	logic [CH_IDX_W-1:0]        ch_s2;
	logic [PP_W-1:0]            p_lo_s2, p_hi_s2;

	logic [PROD_W-1:0]          prod;
	logic [Q_W-1:0]             q;
	logic                       over;
	logic [RESULT_W-1:0]        sat;

	logic                       res_valid_q, res_last_q;
	logic [CHANNEL_W-1:0]       res_ch_q;
	logic [RESULT_W-1:0]        res_value_q;
	logic [COUNT_W-1:0]         res_count_q, frame_counter_q;

	// whole pipeline moves unless the output holds an untaken result
	assign adv        = !res_valid_q || results.ready;
	assign item_ready = adv;

	// gain scale follows the register
	always_ff @(posedge clk) begin
		scale_q <= GAIN_SCALE_TABLE[gain_db];
	end

	// dc tracker: offset = (7*offset + sample)/8, truncated toward zero
	always_comb begin
		idx      = item.ch[IDX_W-1:0];
		old_offs = dc_offsets_q[idx];
		t_sum    = (T_W'(old_offs) <<< 3) - T_W'(old_offs) + T_W'(item.sample);
		t_adj    = t_sum[T_W-1] ? t_sum + T_W'(7) : t_sum;
		new_offs = SAMPLE_W'(t_adj >>> 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED_CHANNELS; i++) begin
				dc_offsets_q[i] <= '0;
			end
		end else if (adv && item_valid) begin
			dc_offsets_q[idx] <= new_offs;
		end
	end

	// stage 1: sample and updated offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1     <= item.ch;
			last_s1   <= item.last;
			sample_s1 <= item.sample;
			offs_s1   <= new_offs;
		end
	end

	// stage 2: magnitude of the corrected sample times the two scale halves
	always_comb begin
		diff = DIFF_W'(sample_s1) - DIFF_W'(offs_s1);
		mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2   <= ch_s1;
			last_s2 <= last_s1;
			neg_s2  <= diff[DIFF_W-1];
			p_lo_s2 <= PP_W'(mag) * PP_W'(scale_q[SCALE_HALF-1:0]);
			p_hi_s2 <= PP_W'(mag) * PP_W'(scale_q[SCALE_W-1:SCALE_HALF]);
		end
	end

	// combine, drop the q16 fraction and clamp to 32 bits
	always_comb begin
		prod = (PROD_W'(p_hi_s2) << SCALE_HALF) + PROD_W'(p_lo_s2);
		q    = prod[PROD_W-1:16];
		over = q[Q_W-1:RESULT_W-1] != '0;
		if (neg_s2) begin
			sat = over ? {1'b1, {(RESULT_W-1){1'b0}}} : RESULT_W'(-q[RESULT_W-1:0]);
		end else begin
			sat = over ? {1'b0, {(RESULT_W-1){1'b1}}} : q[RESULT_W-1:0];
		end
	end

	// output register and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q     <= 1'b0;
			frame_counter_q <= '0;
		end else if (adv) begin
			res_valid_q <= v_s2;
			if (v_s2 && last_s2) begin
				frame_counter_q <= frame_counter_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_ch_q    <= ch_s2[CHANNEL_W-1:0];
			res_value_q <= sat;
			res_last_q  <= last_s2;
			res_count_q <= last_s2 ? frame_counter_q + COUNT_W'(1) : frame_counter_q;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.channel       = res_ch_q;
	assign results.sample_value  = res_value_q;
	assign results.last_of_frame = res_last_q;
	assign results.frame_count   = res_count_q;

endmodule
